[sv/modexp_pkg.sv]
// Shared types, constants and the control program of the modular exponent block.
// Used by the sequencer, datapath, reducer and top level; depends on nothing.
package modexp_pkg;

   localparam int OPB       = 31;
   localparam int PROD_BITS = 2 * OPB;
   localparam int CNT_BITS  = $clog2(OPB + 1);
   localparam int UPC_BITS  = 5;

   localparam logic [OPB-1:0] MODULUS_RESET = OPB'(1000000007);

   // Program addresses that are jump targets.
   localparam logic [UPC_BITS-1:0] UPC_IDLE     = UPC_BITS'(0);
   localparam logic [UPC_BITS-1:0] UPC_INIT_RED = UPC_BITS'(3);
   localparam logic [UPC_BITS-1:0] UPC_BASE_RED = UPC_BITS'(6);
   localparam logic [UPC_BITS-1:0] UPC_LOOP     = UPC_BITS'(8);
   localparam logic [UPC_BITS-1:0] UPC_MUL_RED  = UPC_BITS'(12);
   localparam logic [UPC_BITS-1:0] UPC_SQUARE   = UPC_BITS'(14);
   localparam logic [UPC_BITS-1:0] UPC_SQ_RED   = UPC_BITS'(16);
   localparam logic [UPC_BITS-1:0] UPC_FINISH   = UPC_BITS'(18);

   typedef enum logic [2:0] {
      MOP_NONE,
      MOP_ONE,
      MOP_BASE,
      MOP_ACC_SQ,
      MOP_SQ_SQ
   } mul_op_type;

   typedef enum logic [1:0] {
      DST_NONE,
      DST_ACC,
      DST_SQ
   } dst_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_START,
      COND_RED_BUSY,
      COND_BIT_CLEAR,
      COND_EXP_ZERO
   } cond_type;

   typedef struct packed {
      mul_op_type          mul_op;
      logic                red_start;
      dst_type             dst;
      logic                exp_shift;
      logic                done;
      cond_type            cond;
      logic [UPC_BITS-1:0] target;
   } ucode_type;

   typedef struct packed {
      logic red_busy;
      logic exp_zero;
      logic exp_bit;
   } status_type;

   function automatic ucode_type uword(input mul_op_type mop, input logic rstart,
                                       input dst_type dst, input logic shift,
                                       input logic done, input cond_type cond,
                                       input logic [UPC_BITS-1:0] target);
      ucode_type w;
      w.mul_op    = mop;
      w.red_start = rstart;
      w.dst       = dst;
      w.exp_shift = shift;
      w.done      = done;
      w.cond      = cond;
      w.target    = target;
      return w;
   endfunction

   // Control store. The accumulator and running square are each formed by a
   // multiply into the product register and a reduction of that product.
   function automatic ucode_type ucode_rom(input logic [UPC_BITS-1:0] upc);
      ucode_type w;
      unique case (upc)
         5'd0:  w = uword(MOP_NONE,   1'b0, DST_NONE, 1'b0, 1'b0, COND_NO_START, UPC_IDLE);
         5'd1:  w = uword(MOP_ONE,    1'b0, DST_NONE, 1'b0, 1'b0, COND_NEVER,    UPC_IDLE);
         5'd2:  w = uword(MOP_NONE,   1'b1, DST_NONE, 1'b0, 1'b0, COND_NEVER,    UPC_IDLE);
         5'd3:  w = uword(MOP_NONE,   1'b0, DST_NONE, 1'b0, 1'b0, COND_RED_BUSY, UPC_INIT_RED);
         5'd4:  w = uword(MOP_BASE,   1'b0, DST_ACC,  1'b0, 1'b0, COND_NEVER,    UPC_IDLE);
         5'd5:  w = uword(MOP_NONE,   1'b1, DST_NONE, 1'b0, 1'b0, COND_NEVER,    UPC_IDLE);
         5'd6:  w = uword(MOP_NONE,   1'b0, DST_NONE, 1'b0, 1'b0, COND_RED_BUSY, UPC_BASE_RED);
         5'd7:  w = uword(MOP_NONE,   1'b0, DST_SQ,   1'b0, 1'b0, COND_NEVER,    UPC_IDLE);
         5'd8:  w = uword(MOP_NONE,   1'b0, DST_NONE, 1'b0, 1'b0, COND_EXP_ZERO, UPC_FINISH);
         5'd9:  w = uword(MOP_NONE,   1'b0, DST_NONE, 1'b0, 1'b0, COND_BIT_CLEAR, UPC_SQUARE);
         5'd10: w = uword(MOP_ACC_SQ, 1'b0, DST_NONE, 1'b0, 1'b0, COND_NEVER,    UPC_IDLE);
         5'd11: w = uword(MOP_NONE,   1'b1, DST_NONE, 1'b0, 1'b0, COND_NEVER,    UPC_IDLE);
         5'd12: w = uword(MOP_NONE,   1'b0, DST_NONE, 1'b0, 1'b0, COND_RED_BUSY, UPC_MUL_RED);
         5'd13: w = uword(MOP_NONE,   1'b0, DST_ACC,  1'b0, 1'b0, COND_NEVER,    UPC_IDLE);
         5'd14: w = uword(MOP_SQ_SQ,  1'b0, DST_NONE, 1'b1, 1'b0, COND_NEVER,    UPC_IDLE);
         5'd15: w = uword(MOP_NONE,   1'b1, DST_NONE, 1'b0, 1'b0, COND_NEVER,    UPC_IDLE);
         5'd16: w = uword(MOP_NONE,   1'b0, DST_NONE, 1'b0, 1'b0, COND_RED_BUSY, UPC_SQ_RED);
         5'd17: w = uword(MOP_NONE,   1'b0, DST_SQ,   1'b0, 1'b0, COND_ALWAYS,   UPC_LOOP);
         5'd18: w = uword(MOP_NONE,   1'b0, DST_NONE, 1'b0, 1'b1, COND_ALWAYS,   UPC_IDLE);
         default: w = uword(MOP_NONE, 1'b0, DST_NONE, 1'b0, 1'b0, COND_ALWAYS,   UPC_IDLE);
      endcase
      return w;
   endfunction

endpackage

[sv/modexp_reducer.sv]
// Iterative modular reducer: remainder of a double-width product by the modulus.
// One quotient bit per cycle, restoring compare and subtract; uses modexp_pkg.
module modexp_reducer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [modexp_pkg::PROD_BITS-1:0] prod,
   input  logic [modexp_pkg::OPB-1:0]     modulus,
   output logic                           busy,
   output logic [modexp_pkg::OPB-1:0]     rem
);
   import modexp_pkg::*;

   logic [OPB-1:0]      rem_ff, rem_in;
   logic [OPB-1:0]      low_ff, low_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic [OPB:0]        trial;

   // The upper half of a product of two reduced operands is already below the
   // modulus, so only the lower half needs to be shifted through.
   assign trial = {rem_ff, low_ff[OPB-1]};

   always_comb begin
      rem_in  = rem_ff;
      low_in  = low_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = prod[PROD_BITS-1:OPB];
         low_in  = prod[OPB-1:0];
         cnt_in  = CNT_BITS'(OPB);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, modulus}) begin
            rem_in = OPB'(trial - {1'b0, modulus});
         end else begin
            rem_in = trial[OPB-1:0];
         end
         low_in = {low_ff[OPB-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      low_ff <= low_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   assign busy = busy_ff;
   assign rem  = rem_ff;

endmodule

[sv/modexp_datapath.sv]
// Datapath: operand registers, the multiplier with its product register and the reducer.
// Driven by one control word per cycle; uses modexp_pkg and modexp_reducer.
module modexp_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load,
   input  logic [modexp_pkg::OPB-1:0] base_value,
   input  logic [modexp_pkg::OPB-1:0] exponent,
   input  logic [modexp_pkg::OPB-1:0] modulus,
   input  modexp_pkg::ucode_type      word,
   output modexp_pkg::status_type     status,
   output logic [modexp_pkg::OPB-1:0] result
);
   import modexp_pkg::*;

   logic [OPB-1:0]       base_ff, base_in;
   logic [OPB-1:0]       exp_ff, exp_in;
   logic [OPB-1:0]       acc_ff, acc_in;
   logic [OPB-1:0]       sq_ff, sq_in;
   logic [PROD_BITS-1:0] prod_ff, prod_in;
   logic [OPB-1:0]       mul_a, mul_b;
   logic                 red_busy;
   logic [OPB-1:0]       red_rem;

   always_comb begin
      unique case (word.mul_op)
         MOP_NONE: begin
            mul_a = '0;
            mul_b = '0;
         end
         MOP_ONE: begin
            mul_a = OPB'(1);
            mul_b = OPB'(1);
         end
         MOP_BASE: begin
            mul_a = base_ff;
            mul_b = OPB'(1);
         end
         MOP_ACC_SQ: begin
            mul_a = acc_ff;
            mul_b = sq_ff;
         end
         MOP_SQ_SQ: begin
            mul_a = sq_ff;
            mul_b = sq_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      base_in = load ? base_value : base_ff;
      exp_in  = exp_ff;
      if (load) begin
         exp_in = exponent;
      end else if (word.exp_shift) begin
         exp_in = exp_ff >> 1;
      end
      prod_in = (word.mul_op == MOP_NONE) ? prod_ff : PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
      acc_in  = (word.dst == DST_ACC) ? red_rem : acc_ff;
      sq_in   = (word.dst == DST_SQ) ? red_rem : sq_ff;
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      exp_ff  <= exp_in;
      acc_ff  <= acc_in;
      sq_ff   <= sq_in;
      prod_ff <= prod_in;
   end

   modexp_reducer u_reducer (
      .clock   (clock),
      .reset   (reset),
      .start   (word.red_start),
      .prod    (prod_ff),
      .modulus (modulus),
      .busy    (red_busy),
      .rem     (red_rem)
   );

   assign status.red_busy = red_busy;
   assign status.exp_zero = (exp_ff == '0);
   assign status.exp_bit  = exp_ff[0];

   // A modulus of zero has no reduction; the result is forced to zero.
   assign result = (modulus == '0) ? '0 : acc_ff;

endmodule

[sv/modexp_sequencer.sv]
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Uses the program and types in modexp_pkg.
module modexp_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  modexp_pkg::status_type status,
   output modexp_pkg::ucode_type  word,
   output logic                   busy
);
   import modexp_pkg::*;

   logic [UPC_BITS-1:0] upc_ff, upc_in;
   ucode_type           cur;
   logic                take;

   assign cur = ucode_rom(upc_ff);

   always_comb begin
      unique case (cur.cond)
         COND_NEVER:     take = 1'b0;
         COND_ALWAYS:    take = 1'b1;
         COND_NO_START:  take = !start;
         COND_RED_BUSY:  take = status.red_busy;
         COND_BIT_CLEAR: take = !status.exp_bit;
         COND_EXP_ZERO:  take = status.exp_zero;
         default:        take = 1'b1;
      endcase
      upc_in = take ? cur.target : upc_ff + UPC_BITS'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= UPC_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

   assign word = cur;
   assign busy = (upc_ff != UPC_IDLE);

endmodule

[sv/modular_exponent.sv]
// Modular exponent top level: base to the exponent modulo a programmable modulus.
// Instantiates modexp_sequencer and modexp_datapath; uses modexp_pkg.
//
// A request is taken when start is high and busy is low; the result appears on
// rsp_power_result with rsp_valid high for exactly one cycle and cannot be held
// off. A request runs a setup phase, then a square for every exponent bit up to
// the highest set bit and a multiply for every set bit, then a finish step. Its
// run time is set by the reducer, which retires one remainder bit per cycle and
// is shared by every multiply and square. Exponent zero gives 1 mod modulus; a
// modulus of zero gives a result of zero. The modulus resets to 1000000007 and
// may only be written while busy is low and no result is pending.
module modular_exponent (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [modexp_pkg::OPB-1:0] req_base_value,
   input  logic [modexp_pkg::OPB-1:0] req_exponent,
   output logic                       rsp_valid,
   output logic [modexp_pkg::OPB-1:0] rsp_power_result,
   input  logic                       csr_we,
   input  logic [modexp_pkg::OPB-1:0] csr_wdata
);
   import modexp_pkg::*;

   logic [OPB-1:0] modulus_ff, modulus_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [OPB-1:0] rsp_result_ff, rsp_result_in;
   ucode_type      word;
   status_type     status;
   logic           seq_busy;
   logic           accept;
   logic [OPB-1:0] result;

   assign accept = start && !seq_busy;

   modexp_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .word   (word),
      .busy   (seq_busy)
   );

   modexp_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .base_value (req_base_value),
      .exponent   (req_exponent),
      .modulus    (modulus_ff),
      .word       (word),
      .status     (status),
      .result     (result)
   );

   always_comb begin
      modulus_in    = csr_we ? csr_wdata : modulus_ff;
      rsp_valid_in  = word.done;
      rsp_result_in = word.done ? result : rsp_result_ff;
   end

   always_ff @(posedge clock) begin
      rsp_result_ff <= rsp_result_in;
      if (reset) begin
         modulus_ff   <= MODULUS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         modulus_ff   <= modulus_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy             = seq_busy;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_power_result = rsp_result_ff;

   // The result word goes out as the program returns to idle.
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result word issued while the sequencer is running");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two result words in consecutive cycles");

   a_accept_runs: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted word did not start the program");

   a_reducer_owned: assert property (@(posedge clock) disable iff (reset)
      status.red_busy |-> busy)
      else $error("reducer running while the sequencer is idle");

endmodule

[tb/sv/modular_exponent_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for modular_exponent: base to the exponent modulo a modulus.
// Depends on modexp_pkg for operand widths and the modulus reset value.

import modexp_pkg::*;

// Keeps its own copy of the modulus, predicts each power and checks results in order.
class power_scoreboard;
   logic [OPB-1:0] modulus;
   logic [OPB-1:0] expected_q[$];
   int unsigned    errors;
   int unsigned    results_checked;

   function new();
      modulus         = MODULUS_RESET;
      errors          = 0;
      results_checked = 0;
   endfunction

   function void set_modulus(input logic [OPB-1:0] value);
      modulus = value;
   endfunction

   function int unsigned pending();
      return expected_q.size();
   endfunction

   function void flag(input string what);
      errors++;
      if (errors <= 10) begin
         $display("%0t ns: mismatch: %s", $time, what);
      end
   endfunction

   // Square-and-multiply from the low exponent bit, every product reduced at once.
   function logic [OPB-1:0] power_mod(input logic [OPB-1:0] b, input logic [OPB-1:0] e);
      logic [63:0] m;
      logic [63:0] acc;
      logic [63:0] sq;
      m = 64'(modulus);
      if (m == 64'd0) begin
         return '0;
      end
      acc = 64'd1 % m;
      sq  = 64'(b) % m;
      for (int i = 0; i < OPB; i++) begin
         if (e[i]) begin
            acc = (acc * sq) % m;
         end
         sq = (sq * sq) % m;
      end
      return acc[OPB-1:0];
   endfunction

   function void note_request(input logic [OPB-1:0] b, input logic [OPB-1:0] e);
      expected_q.push_back(power_mod(b, e));
   endfunction

   function void check_power(input logic [OPB-1:0] actual);
      logic [OPB-1:0] want;
      results_checked++;
      if (expected_q.size() == 0) begin
         flag($sformatf("power_result %0d with no request outstanding", actual));
         return;
      end
      want = expected_q.pop_front();
      if (actual !== want) begin
         flag($sformatf("power_result expected %0d, got %0d (modulus %0d)",
                        want, actual, modulus));
      end
   endfunction

   function void finish();
      if (expected_q.size() != 0) begin
         flag($sformatf("%0d results never arrived", expected_q.size()));
      end
   endfunction
endclass

module modular_exponent_test;

   logic           clock;
   logic           reset          = 1'b1;
   logic           start          = 1'b0;
   logic           busy;
   logic [OPB-1:0] req_base_value = '0;
   logic [OPB-1:0] req_exponent   = '0;
   logic           rsp_valid;
   logic [OPB-1:0] rsp_power_result;
   logic           csr_we         = 1'b0;
   logic [OPB-1:0] csr_wdata      = '0;

   power_scoreboard sb = new();

   logic [OPB-1:0] cur_modulus    = MODULUS_RESET;
   int unsigned    idle_pct       = 16;
   int unsigned    words_sent     = 0;
   int unsigned    modulus_writes = 0;

   modular_exponent dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_base_value   (req_base_value),
      .req_exponent     (req_exponent),
      .rsp_valid        (rsp_valid),
      .rsp_power_result (rsp_power_result),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Watch the ports at each edge: register writes, accepted words and results.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) begin
            sb.set_modulus(csr_wdata);
         end
         if (rsp_valid) begin
            sb.check_power(rsp_power_result);
         end
         if (start && !busy) begin
            sb.note_request(req_base_value, req_exponent);
         end
      end
   end

   // Start stays high from one word to the next unless a gap is inserted.
   task automatic send_power(input logic [OPB-1:0] b, input logic [OPB-1:0] e);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(40, 1)) @(posedge clock);
      end
      start          <= 1'b1;
      req_base_value <= b;
      req_exponent   <= e;
      do @(posedge clock); while (busy);
      words_sent++;
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (busy || sb.pending() != 0);
   endtask

   task automatic write_modulus(input logic [OPB-1:0] value);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we      <= 1'b0;
      cur_modulus  = value;
      modulus_writes++;
   endtask

   // Half of the exponents are short so the run stays quick; the rest span all bits.
   task automatic send_random(input int count);
      logic [OPB-1:0] b;
      logic [OPB-1:0] e;
      int unsigned    pick;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 60) b = OPB'($urandom());
         else if (pick < 75) b = cur_modulus + OPB'($urandom_range(2)) - OPB'(1);
         else if (pick < 90) b = OPB'($urandom_range(3));
         else b = '1;
         pick = $urandom_range(99);
         if (pick < 50) e = OPB'($urandom_range(63));
         else if (pick < 85) e = OPB'($urandom());
         else if (pick < 92) e = OPB'(1) << $urandom_range(OPB - 1);
         else e = '1;
         send_power(b, e);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset modulus: zero base and exponent, all-ones fields, bases at the modulus.
      send_power('0, '0);
      send_power('0, OPB'(5));
      send_power(OPB'(1), '1);
      send_power('1, '0);
      send_power('1, '1);
      send_power(OPB'(2), OPB'(30));
      send_power(MODULUS_RESET, OPB'(3));
      send_power(MODULUS_RESET + OPB'(1), '1);
      send_power(MODULUS_RESET - OPB'(1), OPB'(2));
      send_random(45);

      // A modulus of one makes every result zero.
      write_modulus(OPB'(1));
      send_power(OPB'(5), '0);
      send_power('1, '1);
      send_random(15);

      // Zero modulus has no reduction defined and must give zero.
      write_modulus('0);
      send_power(OPB'(7), OPB'(3));
      send_power('0, '0);
      send_random(10);

      idle_pct = 58;
      write_modulus('1);
      send_power('1, '1);
      send_power('1 - OPB'(1), '1);
      send_power(OPB'(2), OPB'(31));
      send_power('1 - OPB'(1), OPB'(2));
      send_random(50);

      write_modulus(OPB'(2));
      send_random(20);

      write_modulus(OPB'($urandom_range(32'h7FFF_FFFF, 32'h0100_0000)));
      send_random(60);

      idle_pct = 0;
      write_modulus(OPB'($urandom_range(1000, 3)));
      send_random(40);

      write_modulus(OPB'(1) << (OPB - 1));
      send_random(50);

      drain();
      repeat (2400) @(posedge clock);
      sb.finish();

      $display("Sent %0d words across %0d modulus writes; checked %0d results.",
               words_sent, modulus_writes, sb.results_checked);
      if (sb.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches in total", sb.errors);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
